// File: hdl/rotating_ring_list_assert.svh
// ----------------------------------------------------------------------------
// rotating_ring_list_assert.svh
// Assertion macros for the rotating ring list. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ROTATING_RING_LIST_ASSERT_SVH
`define ROTATING_RING_LIST_ASSERT_SVH

`ifndef SYNTHESIS

// Check a consequence in the same cycle as its condition
`define RRL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rotating_ring_list: assertion failed");

// Check a consequence in the cycle after its condition
`define RRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rotating_ring_list: assertion failed");

`else

`define RRL_ASSERT_SAME(label, clk, rst, ante, cons)
`define RRL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/rrl_pkg.sv
// ----------------------------------------------------------------------------
// rrl_pkg
// Shared sizes, command and status codes, and the cell control bundle of the
// rotating ring list.
// ----------------------------------------------------------------------------
package rrl_pkg;

   // Sizes
   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int INDEX_WIDTH = $clog2(DEPTH);
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // Command codes
   localparam logic [2:0] CMD_ADD      = 3'd0;
   localparam logic [2:0] CMD_REMOVE   = 3'd1;
   localparam logic [2:0] CMD_FORWARD  = 3'd2;
   localparam logic [2:0] CMD_BACKWARD = 3'd3;
   localparam logic [2:0] CMD_CONTAINS = 3'd4;
   localparam logic [2:0] CMD_CLEAR    = 3'd5;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Cell operations
   typedef logic [1:0] cell_op_type;
   localparam cell_op_type CELL_HOLD      = 2'd0;
   localparam cell_op_type CELL_TAKE_PREV = 2'd1;
   localparam cell_op_type CELL_TAKE_NEXT = 2'd2;

   // Control bundle broadcast from the sequencer to every cell
   typedef struct packed {
      cell_op_type             op;
      logic                    load_key;
      logic [COUNT_WIDTH-1:0]  count;
   } cell_ctrl_type;

endpackage

// File: hdl/rrl_req_if.sv
// ----------------------------------------------------------------------------
// rrl_req_if
// Command channel: valid/ready handshake with command and item value.
// ----------------------------------------------------------------------------
interface rrl_req_if;
   logic                              valid;
   logic                              ready;
   logic [2:0]                        cmd;
   logic [rrl_pkg::VALUE_WIDTH-1:0]   item_value;

   modport source (output valid, output cmd, output item_value, input ready);
   modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

// File: hdl/rrl_rsp_if.sv
// ----------------------------------------------------------------------------
// rrl_rsp_if
// Response channel: valid/ready handshake with head value, count and flags.
// ----------------------------------------------------------------------------
interface rrl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rrl_pkg::VALUE_WIDTH-1:0]   head_value;
   logic [rrl_pkg::COUNT_WIDTH-1:0]   entry_total;
   logic                              is_empty;
   logic                              found;
   logic [1:0]                        status;

   modport source (output valid, output head_value, output entry_total,
                   output is_empty, output found, output status, input ready);
   modport sink   (input valid, input head_value, input entry_total,
                   input is_empty, input found, input status, output ready);
endinterface

// File: hdl/rrl_cell.sv
// ----------------------------------------------------------------------------
// rrl_cell
// One slot of the value chain. Cell 0 is the head; cell k holds the entry k
// steps after the head. Each cycle a cell holds, takes its lower neighbor, or
// takes its upper neighbor (the last live cell wraps around to the head).
// ----------------------------------------------------------------------------
module rrl_cell (
   input  logic                              clock,
   input  rrl_pkg::cell_ctrl_type            cell_ctrl,
   input  logic [rrl_pkg::INDEX_WIDTH-1:0]   cell_index,
   input  logic [rrl_pkg::VALUE_WIDTH-1:0]   prev_value,
   input  logic [rrl_pkg::VALUE_WIDTH-1:0]   next_value,
   input  logic [rrl_pkg::VALUE_WIDTH-1:0]   head_value,
   output logic [rrl_pkg::VALUE_WIDTH-1:0]   value_out
);

   logic [rrl_pkg::VALUE_WIDTH-1:0] value_ff;
   logic [rrl_pkg::VALUE_WIDTH-1:0] value_in;
   logic                            is_last;

   // Last live cell: position equals count minus one
   assign is_last = (cell_ctrl.count ==
                     (rrl_pkg::COUNT_WIDTH'(cell_index) + rrl_pkg::COUNT_WIDTH'(1)));

   // Select the next value
   always_comb begin
      value_in = value_ff;
      case (cell_ctrl.op)
         rrl_pkg::CELL_TAKE_PREV: value_in = prev_value;
         rrl_pkg::CELL_TAKE_NEXT: value_in = is_last ? head_value : next_value;
         default:                 value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

// File: hdl/rrl_ctrl.sv
// ----------------------------------------------------------------------------
// rrl_ctrl
// Command sequencer: decodes each transaction, keeps the entry count, steps
// the cell chain, runs the search rotation and holds the response register.
// ----------------------------------------------------------------------------
module rrl_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   rrl_req_if.sink                           req_port,
   rrl_rsp_if.source                         rsp_port,
   input  logic [rrl_pkg::VALUE_WIDTH-1:0]   head_value,
   output rrl_pkg::cell_ctrl_type            cell_ctrl
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DONE   = 2'd2;

   logic [1:0]                        state_ff,  state_in;
   logic [rrl_pkg::COUNT_WIDTH-1:0]   count_ff,  count_in;
   logic [rrl_pkg::COUNT_WIDTH-1:0]   search_ff, search_in;
   logic [rrl_pkg::VALUE_WIDTH-1:0]   key_ff,    key_in;
   logic                              found_ff,  found_in;
   logic [1:0]                        status_ff, status_in;
   rrl_pkg::cell_op_type              cell_op;
   logic                              load_key;
   logic                              list_empty;
   logic                              rsp_load;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rrl_pkg::VALUE_WIDTH-1:0]   rsp_head_ff;
   logic [rrl_pkg::COUNT_WIDTH-1:0]   rsp_total_ff;
   logic                              rsp_empty_ff;
   logic                              rsp_found_ff;
   logic [1:0]                        rsp_status_ff;

   assign list_empty = (count_ff == '0);
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_port.ready);

   // Decode the command and sequence the chain
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      search_in = search_ff;
      key_in    = key_ff;
      found_in  = found_ff;
      status_in = status_ff;
      cell_op   = rrl_pkg::CELL_HOLD;
      load_key  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               key_in    = req_port.item_value;
               found_in  = 1'b0;
               status_in = rrl_pkg::STATUS_OK;
               state_in  = ST_DONE;
               unique case (req_port.cmd)
                  rrl_pkg::CMD_ADD: begin
                     if (count_ff == rrl_pkg::COUNT_WIDTH'(rrl_pkg::DEPTH)) begin
                        status_in = rrl_pkg::STATUS_FULL;
                     end else begin
                        cell_op  = rrl_pkg::CELL_TAKE_PREV;
                        load_key = 1'b1;
                        count_in = count_ff + rrl_pkg::COUNT_WIDTH'(1);
                     end
                  end
                  rrl_pkg::CMD_REMOVE: begin
                     if (list_empty) begin
                        status_in = rrl_pkg::STATUS_EMPTY;
                     end else begin
                        cell_op  = rrl_pkg::CELL_TAKE_NEXT;
                        count_in = count_ff - rrl_pkg::COUNT_WIDTH'(1);
                     end
                  end
                  rrl_pkg::CMD_FORWARD: begin
                     if (list_empty) begin
                        status_in = rrl_pkg::STATUS_EMPTY;
                     end else begin
                        cell_op = rrl_pkg::CELL_TAKE_NEXT;
                     end
                  end
                  rrl_pkg::CMD_BACKWARD: begin
                     if (list_empty) begin
                        status_in = rrl_pkg::STATUS_EMPTY;
                     end else begin
                        cell_op = rrl_pkg::CELL_TAKE_PREV;
                     end
                  end
                  rrl_pkg::CMD_CONTAINS: begin
                     if (!list_empty) begin
                        search_in = count_ff;
                        state_in  = ST_SEARCH;
                     end
                  end
                  rrl_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // Rotate once around the ring, comparing the head each step
            cell_op   = rrl_pkg::CELL_TAKE_NEXT;
            found_in  = found_ff | (head_value == key_ff);
            search_in = search_ff - rrl_pkg::COUNT_WIDTH'(1);
            if (search_ff == rrl_pkg::COUNT_WIDTH'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_port.ready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      search_ff <= search_in;
      key_ff    <= key_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   // Response register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_head_ff   <= list_empty ? '0 : head_value;
         rsp_total_ff  <= count_ff;
         rsp_empty_ff  <= list_empty;
         rsp_found_ff  <= found_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign req_port.ready       = (state_ff == ST_IDLE);
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.head_value  = rsp_head_ff;
   assign rsp_port.entry_total = rsp_total_ff;
   assign rsp_port.is_empty    = rsp_empty_ff;
   assign rsp_port.found       = rsp_found_ff;
   assign rsp_port.status      = rsp_status_ff;

   assign cell_ctrl.op       = cell_op;
   assign cell_ctrl.load_key = load_key;
   assign cell_ctrl.count    = count_ff;

endmodule

// File: hdl/rotating_ring_list.sv
// ----------------------------------------------------------------------------
// rotating_ring_list
// Bounded circular list of values with a head position, built as a chain of
// value cells kept in ring order from the head.
// ----------------------------------------------------------------------------
// The list holds up to DEPTH values in a row of cells; cell 0 is always the
// head and the chain shifts as a whole to add, remove or rotate. Add, remove,
// move forward, move backward, clear, unknown commands and a contains on an
// empty list go from acceptance straight to the done state, where the
// response is loaded into the output register; the next command is accepted
// once that load has happened. Contains on a non-empty list first passes
// through the search state, which rotates the chain once around, comparing
// the head cell at each step, which leaves the list as it was, and then goes
// to the done state. The response sits in an output register, so the next
// command is accepted while a response still waits; the next response then
// waits for the output register to free up.
module rotating_ring_list (
   input  logic          clock,
   input  logic          reset,
   rrl_req_if.sink       req_port,
   rrl_rsp_if.source     rsp_port
);

`include "rotating_ring_list_assert.svh"

   rrl_pkg::cell_ctrl_type            cell_ctrl;
   logic [rrl_pkg::VALUE_WIDTH-1:0]   cell_value [rrl_pkg::DEPTH];
   logic [rrl_pkg::VALUE_WIDTH-1:0]   prev_value [rrl_pkg::DEPTH];
   logic [rrl_pkg::VALUE_WIDTH-1:0]   next_value [rrl_pkg::DEPTH];
   logic [rrl_pkg::INDEX_WIDTH-1:0]   last_index;
   logic [rrl_pkg::VALUE_WIDTH-1:0]   last_value;
   logic [rrl_pkg::VALUE_WIDTH-1:0]   front_value;

   // Sequencer
   rrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .rsp_port   (rsp_port),
      .head_value (cell_value[0]),
      .cell_ctrl  (cell_ctrl)
   );

   // Feed the head cell: the new value on add, the tail on a backward step
   assign last_index  = rrl_pkg::INDEX_WIDTH'(cell_ctrl.count - rrl_pkg::COUNT_WIDTH'(1));
   assign last_value  = cell_value[last_index];
   assign front_value = cell_ctrl.load_key ? req_port.item_value : last_value;

   // Chain of cells
   for (genvar i = 0; i < rrl_pkg::DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_value[i] = front_value;
      end else begin : g_inner_prev
         assign prev_value[i] = cell_value[i-1];
      end
      if (i == rrl_pkg::DEPTH - 1) begin : g_end
         assign next_value[i] = cell_value[0];
      end else begin : g_inner_next
         assign next_value[i] = cell_value[i+1];
      end

      rrl_cell u_cell (
         .clock      (clock),
         .cell_ctrl  (cell_ctrl),
         .cell_index (rrl_pkg::INDEX_WIDTH'(i)),
         .prev_value (prev_value[i]),
         .next_value (next_value[i]),
         .head_value (cell_value[0]),
         .value_out  (cell_value[i])
      );
   end

   // Checks
   `RRL_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_port.valid && req_port.ready, !req_port.ready)
   `RRL_ASSERT_SAME(a_empty_matches_total, clock, reset,
      rsp_port.valid, rsp_port.is_empty == (rsp_port.entry_total == '0))
   `RRL_ASSERT_SAME(a_empty_head_zero, clock, reset,
      rsp_port.valid && rsp_port.is_empty, rsp_port.head_value == '0 && !rsp_port.found)
   `RRL_ASSERT_SAME(a_total_bounded, clock, reset,
      rsp_port.valid, rsp_port.entry_total <= rrl_pkg::COUNT_WIDTH'(rrl_pkg::DEPTH))

endmodule
